// ===== hw/rtl/boolean_network_attractor_walk_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Boolean network walk block
// Shared property forms, used by the bnaw_dp module of this block.
// ----------------------------------------------------------------------------
`ifndef BOOLEAN_NETWORK_ATTRACTOR_WALK_TOP_ASSERT_SVH
`define BOOLEAN_NETWORK_ATTRACTOR_WALK_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define BNAW_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define BNAW_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/bnaw_pkg.sv =====
// ----------------------------------------------------------------------------
// bnaw_pkg
// Types, constants and the network update function of the Boolean network walk.
// ----------------------------------------------------------------------------
package bnaw_pkg;

    localparam int NODES      = 6;
    localparam int EDGE_W     = NODES * NODES;
    localparam int NUM_STATES = 1 << NODES;
    localparam int IDX_W      = NODES;
    localparam int EPOCH_W    = NODES;
    localparam int APB_DW     = 64;
    localparam int APB_AW     = 4;

    localparam logic [NODES-1:0]   NODE_MASK = {NODES{1'b1}};
    localparam logic [IDX_W-1:0]   IDX_MAX   = {IDX_W{1'b1}};
    // Tag zero marks a cleared entry, so runs use epochs one to EPOCH_MAX.
    localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};

    // Register index, taken from paddr[3].
    localparam logic REG_ACTIVATION = 1'b0;
    localparam logic REG_INHIBITION = 1'b1;

    typedef struct packed {
        logic load;   // start a run from the accepted stimulus set
        logic step;   // emit the current state and advance
        logic clear;  // zero one entry of the visited tag memory
    } t_cmd;

    typedef struct packed {
        logic out_free;    // the output register can take a result this cycle
        logic last;        // the current state is the final distinct one
        logic clr_done;    // the clearing pass is at its final entry
        logic epoch_full;  // no fresh epoch is left for another run
    } t_sts;

    // One synchronous update. Inhibition wins over activation, self-edges are
    // ignored and stimulus nodes are held at one.
    function automatic logic [NODES-1:0] next_state(
        input logic [NODES-1:0]  prev,
        input logic [NODES-1:0]  stim,
        input logic [EDGE_W-1:0] act_mask,
        input logic [EDGE_W-1:0] inh_mask
    );
        logic [NODES-1:0] nxt;
        logic             act;
        logic             inh;
        nxt = '0;
        for (int i = 0; i < NODES; i++) begin
            act = 1'b0;
            inh = 1'b0;
            for (int j = 0; j < NODES; j++) begin
                if (i != j && prev[j]) begin
                    if (inh_mask[i*NODES+j]) begin
                        inh = 1'b1;
                    end else if (act_mask[i*NODES+j]) begin
                        act = 1'b1;
                    end
                end
            end
            nxt[i] = stim[i] | (act & ~inh);
        end
        return nxt;
    endfunction

endpackage

// ===== hw/rtl/bnaw_cfg.sv =====
// ----------------------------------------------------------------------------
// bnaw_cfg
// APB register file holding the activation and inhibition edge masks.
// ----------------------------------------------------------------------------
module bnaw_cfg
    import bnaw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output logic [EDGE_W-1:0] o_act_mask,
    output logic [EDGE_W-1:0] o_inh_mask
);

    logic [EDGE_W-1:0] r_act;
    logic [EDGE_W-1:0] r_inh;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= '0;
            r_inh <= '0;
        end else if (wr_en) begin
            case (paddr[3])
                REG_ACTIVATION: r_act <= pwdata[EDGE_W-1:0];
                REG_INHIBITION: r_inh <= pwdata[EDGE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3])
            REG_ACTIVATION: prdata = {{(APB_DW-EDGE_W){1'b0}}, r_act};
            REG_INHIBITION: prdata = {{(APB_DW-EDGE_W){1'b0}}, r_inh};
            default:        prdata = '0;
        endcase
    end

    assign o_act_mask = r_act;
    assign o_inh_mask = r_inh;

endmodule

// ===== hw/rtl/bnaw_dp.sv =====
// ----------------------------------------------------------------------------
// bnaw_dp
// Datapath: run state, visited tag memory, update logic and output register.
// ----------------------------------------------------------------------------
module bnaw_dp
    import bnaw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic [NODES-1:0]  i_stim,
    input  logic [EDGE_W-1:0] i_act_mask,
    input  logic [EDGE_W-1:0] i_inh_mask,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic [NODES-1:0]  o_state_vector,
    output logic [IDX_W-1:0]  o_state_index,
    output logic              o_last
);

    `include "boolean_network_attractor_walk_top_assert.svh"

    logic [NODES-1:0]   r_stim;
    logic [NODES-1:0]   r_state;
    logic [IDX_W-1:0]   r_index;
    logic [EPOCH_W-1:0] r_tag_mem [NUM_STATES];
    logic [EPOCH_W-1:0] r_rd_tag;
    logic               r_rd_valid;
    logic               r_rd_prev;
    logic [EPOCH_W-1:0] r_epoch;
    logic [NODES-1:0]   r_clr_addr;
    logic               r_o_valid;
    logic [NODES-1:0]   r_o_state;
    logic [IDX_W-1:0]   r_o_index;
    logic               r_o_last;

    logic [NODES-1:0]   n_state;
    logic [NODES-1:0]   look_state;
    logic               hit;
    logic               is_last;
    logic               mem_we;
    logic [NODES-1:0]   mem_waddr;
    logic [EPOCH_W-1:0] mem_wdata;

    assign n_state    = next_state(r_state, r_stim, i_act_mask, i_inh_mask);
    assign look_state = next_state(n_state, r_stim, i_act_mask, i_inh_mask);

    // The tag memory is read one state ahead, so its data is the lookup for the
    // successor of the current state. The state written in that same cycle and
    // the current state itself are covered by compares instead.
    assign hit     = r_rd_valid & (r_rd_tag == r_epoch);
    assign is_last = hit | r_rd_prev | (n_state == r_state) | (r_index == IDX_MAX);

    assign o_sts.out_free   = ~r_o_valid | ~i_out_stall;
    assign o_sts.last       = is_last;
    assign o_sts.clr_done   = (r_clr_addr == NODE_MASK);
    assign o_sts.epoch_full = (r_epoch == EPOCH_MAX);

    assign mem_we    = i_cmd.clear | i_cmd.step;
    assign mem_waddr = i_cmd.clear ? r_clr_addr : r_state;
    assign mem_wdata = i_cmd.clear ? '0 : r_epoch;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_tag_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.step) begin
            r_rd_tag <= r_tag_mem[look_state];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch    <= '0;
            r_clr_addr <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                r_epoch    <= '0;
            end else if (i_cmd.load) begin
                r_epoch <= r_epoch + 1'b1;
            end
            if (i_cmd.step) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_stim     <= i_stim & NODE_MASK;
            r_state    <= i_stim & NODE_MASK;
            r_index    <= '0;
            r_rd_valid <= 1'b0;
            r_rd_prev  <= 1'b0;
        end else if (i_cmd.step) begin
            r_state    <= n_state;
            r_index    <= r_index + 1'b1;
            r_rd_valid <= 1'b1;
            r_rd_prev  <= (look_state == r_state);
        end
        if (i_cmd.step) begin
            r_o_state <= r_state;
            r_o_index <= r_index;
            r_o_last  <= is_last;
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_state_vector = r_o_state;
    assign o_state_index  = r_o_index;
    assign o_last         = r_o_last;

    `BNAW_ASSERT_IMP(a_step_needs_room, i_clk, i_rst_n, i_cmd.step, o_sts.out_free, "step while output register is full")
    `BNAW_ASSERT_IMP(a_emitted_marked, i_clk, i_rst_n, r_o_valid && !r_o_last, r_tag_mem[r_o_state] == r_epoch, "emitted state not marked visited")
    `BNAW_ASSERT_IMP(a_full_run_ends, i_clk, i_rst_n, i_cmd.step && r_index == IDX_MAX, is_last, "run longer than the state space")
    `BNAW_ASSERT_IMP(a_clear_alone, i_clk, i_rst_n, i_cmd.step || i_cmd.load, !i_cmd.clear, "clearing pass overlaps a run")
    `BNAW_ASSERT_IMP(a_epoch_live, i_clk, i_rst_n, i_cmd.step, r_epoch != '0, "step with the cleared tag as epoch")

endmodule

// ===== hw/rtl/bnaw_ctrl.sv =====
// ----------------------------------------------------------------------------
// bnaw_ctrl
// Controller: clears the tag memory, accepts a stimulus set, then steps the datapath until the run ends.
// ----------------------------------------------------------------------------
module bnaw_ctrl
    import bnaw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN
    } t_state;

    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            case (r_state)
                ST_CLEAR: begin
                    if (i_sts.clr_done) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    // Once every epoch has been used the tags are cleared again.
                    if (i_sts.out_free && i_sts.last) begin
                        r_state <= i_sts.epoch_full ? ST_CLEAR : ST_IDLE;
                    end
                end
                default: r_state <= ST_CLEAR;
            endcase
        end
    end

    // The last result of a run may still sit in the output register while the
    // next transaction is taken in.
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cmd.load  = (r_state == ST_IDLE) & i_in_valid;
    assign o_cmd.step  = (r_state == ST_RUN) & i_sts.out_free;
    assign o_cmd.clear = (r_state == ST_CLEAR);

endmodule

// ===== hw/rtl/boolean_network_attractor_walk_top.sv =====
// ----------------------------------------------------------------------------
// boolean_network_attractor_walk_top
// Walks a six-node synchronous Boolean network from a stimulus set and emits
// every distinct state of the run until a state would repeat.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  input     in         i_valid / o_stall    i_stimulus_set
//  output    out        o_valid / i_stall    o_state_vector, o_state_index, o_last
//  config    in         APB psel / penable   paddr, pwdata, prdata
//
//  A run loads the stimulus set and opens a new epoch, then makes one network
//  update per emitted state. An output stall holds the update loop.
//  The visited map is a 64-entry tag memory, read one state ahead; an entry
//  counts as visited when its tag equals the epoch of the run.
//  Reset is synchronous and active low; after it, and after every 63rd run, a
//  clearing pass zeroes the tags while the input is stalled.
// ----------------------------------------------------------------------------
module boolean_network_attractor_walk_top
    import bnaw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [NODES-1:0]  i_stimulus_set,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [NODES-1:0]  o_state_vector,
    output logic [IDX_W-1:0]  o_state_index,
    output logic              o_last,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [EDGE_W-1:0] act_mask;
    logic [EDGE_W-1:0] inh_mask;
    t_cmd              cmd;
    t_sts              sts;

    bnaw_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_act_mask (act_mask),
        .o_inh_mask (inh_mask)
    );

    bnaw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_stall (o_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bnaw_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_stim         (i_stimulus_set),
        .i_act_mask     (act_mask),
        .i_inh_mask     (inh_mask),
        .i_out_stall    (i_stall),
        .o_out_valid    (o_valid),
        .o_state_vector (o_state_vector),
        .o_state_index  (o_state_index),
        .o_last         (o_last)
    );

endmodule

// ===== tb/sv/boolean_network_attractor_walk_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boolean network walk checker
// Watches the stimulus, result and register channels of the network walk
// block. It keeps its own copy of the edge masks, works out every state of a
// walk when a stimulus transaction is accepted, and compares each accepted
// result transaction with the oldest state still owed.
// ----------------------------------------------------------------------------
module boolean_network_attractor_walk_checker
    import bnaw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [NODES-1:0]  i_stimulus_set,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [NODES-1:0]  i_state_vector,
    input  logic [IDX_W-1:0]  i_state_index,
    input  logic              i_last,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [APB_AW-1:0] i_paddr,
    input  logic [APB_DW-1:0] i_pwdata,
    input  logic [APB_DW-1:0] i_prdata,
    input  logic              i_pready,
    output int                o_errors,
    output int                o_pending,
    output int                o_checked
);

    typedef struct packed {
        logic [NODES-1:0] vec;
        logic [IDX_W-1:0] idx;
        logic             last;
    } t_walk_state;

    t_walk_state       owed_states[$];
    logic [EDGE_W-1:0] act_edges;
    logic [EDGE_W-1:0] inh_edges;
    int                mismatch_count = 0;
    int                owed_count     = 0;
    int                state_count    = 0;

    assign o_errors  = mismatch_count;
    assign o_pending = owed_count;
    assign o_checked = state_count;

    // One synchronous update of the whole network.
    function automatic logic [NODES-1:0] advance_network(
        input logic [NODES-1:0] cur,
        input logic [NODES-1:0] stim
    );
        logic [NODES-1:0] nxt;
        logic             excited;
        logic             blocked;
        nxt = '0;
        for (int n = 0; n < NODES; n++) begin
            excited = 1'b0;
            blocked = 1'b0;
            for (int p = 0; p < NODES; p++) begin
                if (p != n && cur[p]) begin
                    if (inh_edges[n*NODES+p]) begin
                        blocked = 1'b1;
                    end else if (act_edges[n*NODES+p]) begin
                        excited = 1'b1;
                    end
                end
            end
            nxt[n] = stim[n] || (excited && !blocked);
        end
        return nxt;
    endfunction

    // Queues every distinct state of the walk that starts from this stimulus.
    task automatic predict_walk(input logic [NODES-1:0] stim);
        logic             seen[NUM_STATES];
        logic [NODES-1:0] cur;
        logic [NODES-1:0] nxt;
        logic             done;
        int               count;
        t_walk_state      entry;
        foreach (seen[k]) seen[k] = 1'b0;
        cur   = stim;
        count = 0;
        done  = 1'b0;
        while (!done) begin
            seen[cur]  = 1'b1;
            nxt        = advance_network(cur, stim);
            done       = seen[nxt] || (count + 1 >= NUM_STATES);
            entry.vec  = cur;
            entry.idx  = count[IDX_W-1:0];
            entry.last = done;
            owed_states.push_back(entry);
            count++;
            cur = nxt;
        end
    endtask

    always @(posedge i_clk) begin
        t_walk_state       want;
        logic [APB_DW-1:0] readback;
        if (!i_rst_n) begin
            owed_states.delete();
            act_edges = '0;
            inh_edges = '0;
        end else begin
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    if (i_paddr[APB_AW-1] == REG_INHIBITION) begin
                        inh_edges = i_pwdata[EDGE_W-1:0];
                    end else begin
                        act_edges = i_pwdata[EDGE_W-1:0];
                    end
                end else begin
                    readback = '0;
                    readback[EDGE_W-1:0] = (i_paddr[APB_AW-1] == REG_INHIBITION) ?
                                           inh_edges : act_edges;
                    if (i_prdata !== readback) begin
                        mismatch_count++;
                        $display("%0t: register read at %0h: expected %0h, got %0h",
                                 $time, i_paddr, readback, i_prdata);
                    end
                end
            end
            // Predict before popping, so that a result in the same cycle still matches.
            if (i_in_valid && !i_in_stall) begin
                predict_walk(i_stimulus_set);
            end
            if (i_out_valid && !i_out_stall) begin
                if (owed_states.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected state: expected none, got vec %0h idx %0d last %0b",
                             $time, i_state_vector, i_state_index, i_last);
                end else begin
                    want = owed_states.pop_front();
                    state_count++;
                    if (i_state_vector !== want.vec) begin
                        mismatch_count++;
                        $display("%0t: state_vector: expected %0h, got %0h",
                                 $time, want.vec, i_state_vector);
                    end
                    if (i_state_index !== want.idx) begin
                        mismatch_count++;
                        $display("%0t: state_index: expected %0d, got %0d",
                                 $time, want.idx, i_state_index);
                    end
                    if (i_last !== want.last) begin
                        mismatch_count++;
                        $display("%0t: last: expected %0b, got %0b",
                                 $time, want.last, i_last);
                    end
                end
            end
        end
        owed_count = owed_states.size();
    end

endmodule

// ===== tb/sv/boolean_network_attractor_walk_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boolean network walk testbench
// Drives stimulus sets and edge-mask settings into the network walk block,
// first a directed set of networks and then random networks under three
// idling patterns, and reports the verdict from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module boolean_network_attractor_walk_top_test;
    import bnaw_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int SEGMENTS       = 6;
    localparam int SEGMENT_ITEMS  = 24;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [NODES-1:0]  i_stimulus_set;
    logic              o_valid;
    logic              i_stall;
    logic [NODES-1:0]  o_state_vector;
    logic [IDX_W-1:0]  o_state_index;
    logic              o_last;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int errors;
    int pending;
    int checked;
    int send_idle_pct    = 21;
    int recv_idle_pct    = 78;
    int walks_sent       = 0;
    int settings_applied = 0;
    int quiet_cycles     = 0;

    boolean_network_attractor_walk_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_stimulus_set (i_stimulus_set),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_state_vector (o_state_vector),
        .o_state_index  (o_state_index),
        .o_last         (o_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    boolean_network_attractor_walk_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_stimulus_set (i_stimulus_set),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_state_vector (o_state_vector),
        .i_state_index  (o_state_index),
        .i_last         (o_last),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_prdata       (prdata),
        .i_pready       (pready),
        .o_errors       (errors),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_stall = ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Any accepted transaction on any channel counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_walk(input logic [NODES-1:0] stim);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid        = 1'b0;
            i_stimulus_set = NODES'($urandom);
            @(negedge i_clk);
        end
        i_valid        = 1'b1;
        i_stimulus_set = stim;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        i_valid = 1'b0;
        walks_sent++;
    endtask

    task automatic wait_drained();
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_transfer(input logic wr, input logic sel, input logic [APB_DW-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = {sel, {(APB_AW-1){1'b0}}};
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Upper data bits carry noise, which the block must drop.
    task automatic set_network(input logic [EDGE_W-1:0] act, input logic [EDGE_W-1:0] inh);
        logic [APB_DW-1:0] data;
        wait_drained();
        data = {$urandom, $urandom};
        data[EDGE_W-1:0] = act;
        apb_transfer(1'b1, REG_ACTIVATION, data);
        data = {$urandom, $urandom};
        data[EDGE_W-1:0] = inh;
        apb_transfer(1'b1, REG_INHIBITION, data);
        apb_transfer(1'b0, REG_ACTIVATION, '0);
        apb_transfer(1'b0, REG_INHIBITION, '0);
        settings_applied++;
    endtask

    function automatic logic [EDGE_W-1:0] pick_mask(input int density);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        c = {$urandom, $urandom};
        case (density)
            0:       return EDGE_W'(a & b & c);
            1:       return EDGE_W'(a & b);
            2:       return EDGE_W'(a);
            3:       return EDGE_W'(a | b);
            default: return c[0] ? '1 : '0;
        endcase
    endfunction

    initial begin
        logic [EDGE_W-1:0] ring;
        logic [EDGE_W-1:0] diag;
        logic [NODES-1:0]  stim;
        int                pick;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_stimulus_set = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        ring           = '0;
        diag           = '0;
        for (int k = 0; k < NODES; k++) begin
            ring[((k + 1) % NODES)*NODES + k] = 1'b1;
            diag[k*NODES + k] = 1'b1;
        end
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: reset masks, a shift ring, both edge kinds on every
        // pair, self-edges only, and the all-ones and all-zero extremes.
        send_walk('0);
        send_walk(NODE_MASK);
        set_network(ring, '0);
        for (int k = 0; k < NODES; k++) send_walk(NODES'(1) << k);
        send_walk('0);
        set_network('1, '1);
        send_walk(6'h15);
        send_walk(6'h2A);
        send_walk('0);
        set_network(diag, '0);
        send_walk(6'h09);
        set_network(ring, diag);
        send_walk(6'h01);
        set_network(diag, diag);
        send_walk(NODE_MASK);
        set_network('1, '0);
        send_walk(6'h01);
        send_walk(6'h20);
        set_network('0, '1);
        send_walk(NODE_MASK);
        send_walk(6'h07);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 78 : 0;
            recv_idle_pct = (phase == 0) ? 78 : (phase == 1) ? 21 : 0;
            for (int seg = 0; seg < SEGMENTS; seg++) begin
                set_network(pick_mask($urandom_range(0, 4)), pick_mask($urandom_range(0, 2)));
                for (int n = 0; n < SEGMENT_ITEMS; n++) begin
                    if ($urandom_range(0, 29) == 0) begin
                        wait_drained();
                    end
                    // Sparse stimulus sets give the longest walks.
                    pick = $urandom_range(0, 9);
                    if (pick < 4) begin
                        stim = NODES'(1) << $urandom_range(0, NODES - 1);
                    end else if (pick == 4) begin
                        stim = '0;
                    end else if (pick == 5) begin
                        stim = NODE_MASK;
                    end else begin
                        stim = NODES'($urandom);
                    end
                    send_walk(stim);
                end
            end
        end

        wait_drained();
        $display("Covered %0d walks over %0d edge-mask settings, %0d states compared.",
                 walks_sent, settings_applied + 1, checked);
        if (pending != 0) begin
            $display("%0t: %0d expected states never arrived", $time, pending);
        end
        if (errors == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
